>>> hdl/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg
// Types and constants shared by the banked memory mapper.
// ----------------------------------------------------------------------------
package bmm_pkg;

  localparam int unsigned PAGE_BYTES = 16384;
  localparam int unsigned OFFSET_W   = 14;

  // operation codes
  localparam logic [2:0] OP_CPU_READ  = 3'd0;
  localparam logic [2:0] OP_CPU_WRITE = 3'd1;
  localparam logic [2:0] OP_MAP       = 3'd2;
  localparam logic [2:0] OP_PAGE_LOAD = 3'd3;
  localparam logic [2:0] OP_PAGE_READ = 3'd4;

  // RAM size select codes
  localparam logic [2:0] SIZE_48K   = 3'd0;
  localparam logic [2:0] SIZE_128K  = 3'd1;
  localparam logic [2:0] SIZE_256K  = 3'd2;
  localparam logic [2:0] SIZE_512K  = 3'd3;
  localparam logic [2:0] SIZE_1024K = 3'd4;

  localparam logic       KIND_ROM = 1'b0;
  localparam logic       KIND_RAM = 1'b1;
  localparam logic [7:0] ROM_RAM0 = 8'hff;  // ROM select that puts RAM 0 in window 0

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [1:0]  window;
    logic        kind;
    logic [7:0]  page;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       write_blocked;
    logic [7:0] rom_selected;
    logic [7:0] ram_selected;
  } rsp_t;

  typedef struct packed {
    logic       is_ram;
    logic [5:0] page;
  } map_entry_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_RAM,
    RD_ROM
  } rd_sel_e;

  function automatic logic [7:0] size_mask(input logic [2:0] sel);
    logic [7:0] m;
    unique case (sel)
      SIZE_128K:  m = 8'h07;
      SIZE_256K:  m = 8'h0f;
      SIZE_512K:  m = 8'h1f;
      SIZE_1024K: m = 8'h3f;
      default:    m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

>>> hdl/bmm_ram.sv
// ----------------------------------------------------------------------------
// bmm_ram
// Single-port synchronous RAM, registered read, no reset on contents.
// ----------------------------------------------------------------------------
module bmm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/banked_memory_mapper.sv
// ----------------------------------------------------------------------------
// banked_memory_mapper
// Four 16K CPU windows mapped onto RAM or ROM pages, plus direct page access.
// ----------------------------------------------------------------------------
// An item taken at edge N has its result, with done_o high, in the cycle
//   after edge N (set by the registered read of the page RAMs).
// Throughput: 1 item per cycle; busy stays low. A write then a read of the same
//   byte is safe: the write lands at an earlier edge than the read samples the array.
// Reset: window map to ROM0, RAM5, RAM2, RAM0; selections and size select to 0;
//   page contents are not cleared. The receiver cannot stall results.
module banked_memory_mapper #(
  parameter int unsigned RAM_PAGES = 64,
  parameter int unsigned ROM_PAGES = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bmm_pkg::req_t  req_i,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_wdata_i,
  output logic           done_o,
  output bmm_pkg::rsp_t  rsp_o
);

  // page index widths; a one-page ROM still gets one bit
  localparam int unsigned RPW    = (RAM_PAGES > 1) ? $clog2(RAM_PAGES) : 1;
  localparam int unsigned OPW    = (ROM_PAGES > 1) ? $clog2(ROM_PAGES) : 1;
  localparam int unsigned RAM_D  = RAM_PAGES * bmm_pkg::PAGE_BYTES;
  localparam int unsigned ROM_D  = ROM_PAGES * bmm_pkg::PAGE_BYTES;
  localparam int unsigned RAM_AW = $clog2(RAM_D);
  localparam int unsigned ROM_AW = $clog2(ROM_D);

  // page-number wrap tables, worked out at elaboration
  logic [RPW-1:0] ram_mod_tbl [256];
  logic [OPW-1:0] rom_mod_tbl [256];

  for (genvar v = 0; v < 256; v++) begin : g_mod
    assign ram_mod_tbl[v] = RPW'(v % RAM_PAGES);
    assign rom_mod_tbl[v] = OPW'(v % ROM_PAGES);
  end

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  bmm_pkg::map_entry_t map_q [4];
  bmm_pkg::map_entry_t map_d [4];
  logic [7:0]          rom_num_q, rom_num_d;
  logic [7:0]          ram_num_q, ram_num_d;
  logic [2:0]          size_sel_q, size_sel_d;

  // result stage
  logic                vld_q;
  bmm_pkg::rd_sel_e    rd_sel_q, rd_sel_d;
  logic                blocked_q, blocked_d;
  logic [7:0]          rom_sel_q, ram_sel_q;
  logic [7:0]          rd_data;

  logic                accept;
  bmm_pkg::map_entry_t win_entry;
  logic [7:0]          ram_map_pg;
  logic [RPW-1:0]      ram_pg;
  logic [OPW-1:0]      rom_pg;
  logic [bmm_pkg::OFFSET_W-1:0] offset;

  logic                ram_we, ram_re, rom_we, rom_re;
  logic [RAM_AW-1:0]   ram_addr;
  logic [ROM_AW-1:0]   rom_addr;
  logic [7:0]          ram_rdata, rom_rdata;

  // the mapper never holds an item off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign offset     = req_i.address[bmm_pkg::OFFSET_W-1:0];
  assign win_entry  = map_q[req_i.address[15:14]];
  assign ram_map_pg = req_i.page & bmm_pkg::size_mask(size_sel_q);

  // decode: pick page, enables, next map and selections
  always_comb begin
    map_d      = map_q;
    rom_num_d  = rom_num_q;
    ram_num_d  = ram_num_q;
    rd_sel_d   = bmm_pkg::RD_NONE;
    blocked_d  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    rom_we     = 1'b0;
    rom_re     = 1'b0;
    // CPU ops go through the window map, direct ops wrap the page given
    ram_pg     = win_entry.page[RPW-1:0];
    rom_pg     = win_entry.page[OPW-1:0];

    if (accept) begin
      unique case (req_i.op)
        bmm_pkg::OP_CPU_READ: begin
          if (win_entry.is_ram) begin
            ram_re   = 1'b1;
            rd_sel_d = bmm_pkg::RD_RAM;
          end else begin
            rom_re   = 1'b1;
            rd_sel_d = bmm_pkg::RD_ROM;
          end
        end
        bmm_pkg::OP_CPU_WRITE: begin
          // window 0 is writable only while the ROM select is 0xFF, which pages in RAM 0
          if (req_i.address[15:14] == 2'd0 && rom_num_q != bmm_pkg::ROM_RAM0) begin
            blocked_d = 1'b1;
          end else if (win_entry.is_ram) begin
            ram_we = 1'b1;
          end else begin
            rom_we = 1'b1;
          end
        end
        bmm_pkg::OP_MAP: begin
          if (req_i.kind == bmm_pkg::KIND_RAM) begin
            map_d[req_i.window] = '{is_ram: 1'b1, page: 6'(ram_mod_tbl[ram_map_pg])};
            if (req_i.window == 2'd3) begin
              ram_num_d = req_i.page;
            end
          end else if (req_i.window == 2'd0 && req_i.page == bmm_pkg::ROM_RAM0) begin
            rom_num_d = bmm_pkg::ROM_RAM0;
            map_d[0]  = '{is_ram: 1'b1, page: 6'd0};
          end else begin
            map_d[req_i.window] = '{is_ram: 1'b0, page: 6'(rom_mod_tbl[req_i.page])};
            if (req_i.window == 2'd0) begin
              rom_num_d = req_i.page;
            end
          end
        end
        bmm_pkg::OP_PAGE_LOAD: begin
          ram_pg = ram_mod_tbl[req_i.page];
          rom_pg = rom_mod_tbl[req_i.page];
          if (req_i.kind == bmm_pkg::KIND_RAM) begin
            ram_we = 1'b1;
          end else begin
            rom_we = 1'b1;
          end
        end
        bmm_pkg::OP_PAGE_READ: begin
          ram_pg = ram_mod_tbl[req_i.page];
          rom_pg = rom_mod_tbl[req_i.page];
          if (req_i.kind == bmm_pkg::KIND_RAM) begin
            ram_re   = 1'b1;
            rd_sel_d = bmm_pkg::RD_RAM;
          end else begin
            rom_re   = 1'b1;
            rd_sel_d = bmm_pkg::RD_ROM;
          end
        end
        default: begin
          // unused op codes: result carries only the selections
        end
      endcase
    end
  end

  // byte address = page * 16K + offset
  assign ram_addr = RAM_AW'({ram_pg, offset});
  assign rom_addr = ROM_AW'({rom_pg, offset});

  // size select ignores codes above the largest size
  assign size_sel_d = (cfg_we_i && cfg_wdata_i <= bmm_pkg::SIZE_1024K) ? cfg_wdata_i
                                                                       : size_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q[0]   <= '{is_ram: 1'b0, page: 6'd0};
      map_q[1]   <= '{is_ram: 1'b1, page: 6'd5};
      map_q[2]   <= '{is_ram: 1'b1, page: 6'd2};
      map_q[3]   <= '{is_ram: 1'b1, page: 6'd0};
      rom_num_q  <= 8'd0;
      ram_num_q  <= 8'd0;
      size_sel_q <= bmm_pkg::SIZE_48K;
      vld_q      <= 1'b0;
      rd_sel_q   <= bmm_pkg::RD_NONE;
    end else begin
      map_q      <= map_d;
      rom_num_q  <= rom_num_d;
      ram_num_q  <= ram_num_d;
      size_sel_q <= size_sel_d;
      vld_q      <= accept;
      rd_sel_q   <= rd_sel_d;
    end
  end

  // result payload; selections are those after the item's own update
  always_ff @(posedge clk_i) begin
    if (accept) begin
      blocked_q <= blocked_d;
      rom_sel_q <= rom_num_d;
      ram_sel_q <= ram_num_d;
    end
  end

  bmm_ram #(
    .WIDTH (8),
    .DEPTH (RAM_D)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (req_i.write_data),
    .rdata_o (ram_rdata)
  );

  bmm_ram #(
    .WIDTH (8),
    .DEPTH (ROM_D)
  ) u_rom (
    .clk_i   (clk_i),
    .we_i    (rom_we),
    .re_i    (rom_re),
    .addr_i  (rom_addr),
    .wdata_i (req_i.write_data),
    .rdata_o (rom_rdata)
  );

  always_comb begin
    case (rd_sel_q)
      bmm_pkg::RD_RAM: rd_data = ram_rdata;
      bmm_pkg::RD_ROM: rd_data = rom_rdata;
      default:         rd_data = 8'd0;
    endcase
  end

  assign rsp_o.read_data     = rd_data;
  assign rsp_o.write_blocked = blocked_q;
  assign rsp_o.rom_selected  = rom_sel_q;
  assign rsp_o.ram_selected  = ram_sel_q;
  assign done_o              = vld_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("item gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result without an item");

  a_one_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && rom_we) && !(ram_re && rom_re))
    else $error("both page stores accessed by one item");

  a_blocked_is_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.op != bmm_pkg::OP_CPU_WRITE) |=> !rsp_o.write_blocked)
    else $error("write_blocked on a non-write item");

  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.op != bmm_pkg::OP_CPU_READ && req_i.op != bmm_pkg::OP_PAGE_READ)
    |=> rsp_o.read_data == 8'd0)
    else $error("read_data not zero on a non-read item");

  a_rom_ff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.op == bmm_pkg::OP_MAP && req_i.kind == bmm_pkg::KIND_ROM &&
     req_i.window == 2'd0 && req_i.page == bmm_pkg::ROM_RAM0)
    |=> (map_q[0].is_ram && map_q[0].page == 6'd0 && rom_num_q == bmm_pkg::ROM_RAM0))
    else $error("ROM 0xFF did not page RAM 0 into window 0");

endmodule
